// File: rtl/afpp_pkg.sv
// Shared widths, codes and the adder request type of the frame playout pacer.
package afpp_pkg;

    localparam int PTS_W           = 42;
    localparam int ACC_W           = 46;
    localparam int ANCHOR_W        = 32;
    localparam int DROP_W          = 6;
    localparam int LEVEL_W         = 7;
    localparam int CFG_IDX_W       = 1;
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_START   = 1'b1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int BAND_LOW   = 15;
    localparam int BAND_MID   = 30;
    localparam int BAND_HIGH  = 40;
    localparam int BAND_TOP   = 60;
    localparam int REF_OFFSET = 25;
    localparam int NUDGE_UP   = 10;
    localparam int STEP_MID   = 20;
    localparam int STEP_TOP   = 40;

    localparam logic signed [ACC_W-1:0] ANCHOR_MAX =
        {{(ACC_W-ANCHOR_W+1){1'b0}}, {(ANCHOR_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ANCHOR_MIN =
        {{(ACC_W-ANCHOR_W+1){1'b1}}, {(ANCHOR_W-1){1'b0}}};

    typedef struct packed {
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] b;
        logic                    sub;
    } alu_req_t;

endpackage

// File: rtl/afpp_alu.sv
// Shared add/subtract unit of the frame playout pacer.
module afpp_alu
(
    input  afpp_pkg::alu_req_t                    req,
    output logic signed [afpp_pkg::ACC_W-1:0]     sum
);

    assign sum = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

// File: rtl/adaptive_frame_playout_pacer_core.sv
// Top level of the adaptive frame playout pacer: timestamp queue, anchor and tick sequencer.
//
// Frame timestamps are queued on push words and paced against the wall clock on tick words.
// A push, and a tick on an empty queue, are handled in the idle state alone. Any other tick
// steps the sequencer, for each head frame examined (dropped heads plus the presented one),
// through the queue read, the start-time sums, the band test, an optional anchor nudge and
// the lateness terms, with every sum taken on the single shared adder. One result word is
// produced per input word and held in an output register; the next input word is taken
// once the sequencer is idle and that register is free or being emptied.
module adaptive_frame_playout_pacer_core
#(
    parameter int QUEUE_DEPTH = afpp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [afpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [afpp_pkg::PTS_W-1:0]        cfg_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [afpp_pkg::PTS_W-1:0]        frame_pts,
    input  logic [afpp_pkg::PTS_W-1:0]        now_ms,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              frame_valid,
    output logic [afpp_pkg::PTS_W-1:0]        present_pts,
    output logic [afpp_pkg::DROP_W-1:0]       dropped_count,
    output logic                              push_refused,
    output logic [afpp_pkg::LEVEL_W-1:0]      queue_level
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ACC_W = afpp_pkg::ACC_W;
    localparam int PTS_W = afpp_pkg::PTS_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDH,
        S_RDR,
        S_B0,
        S_B1,
        S_B2,
        S_TEST,
        S_NUDGE,
        S_D,
        S_LATE
    } state_t;

    state_t                            state_reg;
    logic [PTS_W-1:0]                  start_reg;
    logic [PTS_W-1:0]                  wall_reg;
    logic signed [afpp_pkg::ANCHOR_W-1:0] anchor_reg;
    logic [PTR_W-1:0]                  head_ptr_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic [afpp_pkg::DROP_W-1:0]       dropped_reg;
    logic                              nudged_reg;
    logic signed [ACC_W-1:0]           acc_reg;
    logic [PTS_W-1:0]                  head_pts_reg;
    logic [PTS_W-1:0]                  now_reg;
    logic [PTS_W-1:0]                  rd_q_reg;

    logic                              out_valid_reg;
    logic                              frame_valid_reg;
    logic [PTS_W-1:0]                  present_pts_reg;
    logic [afpp_pkg::DROP_W-1:0]       dropped_count_reg;
    logic                              push_refused_reg;
    logic [afpp_pkg::LEVEL_W-1:0]      queue_level_reg;

    logic [PTS_W-1:0]                  queue_mem [QUEUE_DEPTH];

    afpp_pkg::alu_req_t                alu_req;
    logic signed [ACC_W-1:0]           sum;

    logic                              in_accept;
    logic                              out_take;
    logic                              out_load;
    logic                              head_drop;
    logic                              queue_full;
    logic                              push_write;
    logic                              rd_en;
    logic [PTR_W-1:0]                  rd_addr;
    logic [PTR_W-1:0]                  tail_ptr;
    logic [PTR_W-1:0]                  ref_ptr;
    logic [PTR_W-1:0]                  head_inc;
    logic [CNT_W-1:0]                  count_inc;
    logic [CNT_W-1:0]                  count_dec;
    logic                              band_low;
    logic                              band_high;
    logic                              band_top;
    logic                              band_rise;
    logic signed [ACC_W-1:0]           n_ext;
    logic signed [ACC_W-1:0]           n_diff;
    logic signed [ACC_W-1:0]           lead;
    logic signed [ACC_W-1:0]           nudge_delta;
    logic signed [ACC_W-1:0]           wall_ext;
    logic signed [ACC_W-1:0]           anchor_ext;
    logic signed [ACC_W-1:0]           start_ext;
    logic signed [ACC_W-1:0]           now_ext;
    logic signed [ACC_W-1:0]           head_ext;
    logic signed [ACC_W-1:0]           ref_ext;
    logic signed [afpp_pkg::ANCHOR_W-1:0] anchor_sat;
    logic                              sum_neg;
    logic                              sum_pos;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [CNT_W-1:0] off);
        logic [PTR_W:0] s;
        s = (PTR_W+1)'(ptr) + (PTR_W+1)'(off);
        if (s >= (PTR_W+1)'(QUEUE_DEPTH))
        begin
            s = s - (PTR_W+1)'(QUEUE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    afpp_alu u_alu
    (
        .req (alu_req),
        .sum (sum)
    );

    assign out_take   = out_valid_reg && !out_stall;
    assign in_stall   = !((state_reg == S_IDLE) && (!out_valid_reg || !out_stall));
    assign in_accept  = in_valid && !in_stall;
    assign queue_full = (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign push_write = in_accept && (operation == afpp_pkg::OP_PUSH) && !queue_full;

    assign count_inc = count_reg + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);
    assign tail_ptr  = wrap_add(head_ptr_reg, count_reg);
    assign ref_ptr   = wrap_add(head_ptr_reg, count_reg - CNT_W'(afpp_pkg::REF_OFFSET));
    assign head_inc  = wrap_add(head_ptr_reg, CNT_W'(1));

    assign band_low  = (count_reg <= CNT_W'(afpp_pkg::BAND_LOW));
    assign band_high = (count_reg > CNT_W'(afpp_pkg::BAND_HIGH));
    assign band_top  = (count_reg > CNT_W'(afpp_pkg::BAND_TOP));
    assign band_rise = (count_reg > CNT_W'(afpp_pkg::BAND_MID)) && !band_high;

    assign rd_en   = (state_reg == S_RDH) || ((state_reg == S_RDR) && band_high);
    assign rd_addr = (state_reg == S_RDH) ? head_ptr_reg : ref_ptr;

    assign wall_ext   = signed'({{(ACC_W-PTS_W){1'b0}}, wall_reg});
    assign start_ext  = signed'({{(ACC_W-PTS_W){1'b0}}, start_reg});
    assign now_ext    = signed'({{(ACC_W-PTS_W){1'b0}}, now_reg});
    assign head_ext   = signed'({{(ACC_W-PTS_W){1'b0}}, head_pts_reg});
    assign ref_ext    = signed'({{(ACC_W-PTS_W){1'b0}}, rd_q_reg});
    assign anchor_ext = {{(ACC_W-afpp_pkg::ANCHOR_W){anchor_reg[afpp_pkg::ANCHOR_W-1]}},
                         anchor_reg};
    assign n_ext      = signed'(ACC_W'(count_reg));

    // lead term: low band slope 40, rising band 2, high band 20, top band 40
    always_comb
    begin
        n_diff = n_ext - ACC_W'(afpp_pkg::BAND_MID);
        lead   = '0;
        priority if (band_low)
        begin
            n_diff = n_ext - ACC_W'(afpp_pkg::BAND_LOW);
            lead   = (n_diff <<< 5) + (n_diff <<< 3);
        end
        else if (band_top)
        begin
            lead = (n_diff <<< 5) + (n_diff <<< 3);
        end
        else if (band_high)
        begin
            lead = (n_diff <<< 4) + (n_diff <<< 2);
        end
        else if (band_rise)
        begin
            lead = n_diff <<< 1;
        end
        else
        begin
            lead = '0;
        end
    end

    assign nudge_delta = band_high ? (band_top ? -ACC_W'(afpp_pkg::STEP_TOP)
                                               : -ACC_W'(afpp_pkg::STEP_MID))
                                   : ACC_W'(afpp_pkg::NUDGE_UP);

    always_comb
    begin
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
        unique case (state_reg)
            S_B0:
            begin
                alu_req.a = wall_ext;
                alu_req.b = anchor_ext;
            end
            S_B1:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = now_ext;
                alu_req.sub = 1'b1;
            end
            S_B2:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = start_ext;
                alu_req.sub = 1'b1;
            end
            S_TEST:
            begin
                alu_req.a = acc_reg;
                alu_req.b = band_high ? ref_ext : head_ext;
            end
            S_NUDGE:
            begin
                alu_req.a = anchor_ext;
                alu_req.b = nudge_delta;
            end
            S_D:
            begin
                alu_req.a = acc_reg;
                alu_req.b = head_ext;
            end
            S_LATE:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = lead;
                alu_req.sub = 1'b1;
            end
            default:
            begin
                alu_req.a   = '0;
                alu_req.b   = '0;
                alu_req.sub = 1'b0;
            end
        endcase
    end

    assign sum_neg = sum[ACC_W-1];
    assign sum_pos = !sum[ACC_W-1] && (sum != '0);

    assign head_drop = sum_neg && (count_reg > CNT_W'(1));
    assign out_load  = (in_accept && ((operation == afpp_pkg::OP_PUSH) || (count_reg == '0)))
                       || ((state_reg == S_LATE) && !head_drop);

    always_comb
    begin
        priority if (sum > afpp_pkg::ANCHOR_MAX)
        begin
            anchor_sat = afpp_pkg::ANCHOR_MAX[afpp_pkg::ANCHOR_W-1:0];
        end
        else if (sum < afpp_pkg::ANCHOR_MIN)
        begin
            anchor_sat = afpp_pkg::ANCHOR_MIN[afpp_pkg::ANCHOR_W-1:0];
        end
        else
        begin
            anchor_sat = sum[afpp_pkg::ANCHOR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_write)
        begin
            queue_mem[tail_ptr] <= frame_pts;
        end
        if (rd_en)
        begin
            rd_q_reg <= queue_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            start_reg         <= '0;
            wall_reg          <= '0;
            anchor_reg        <= '0;
            head_ptr_reg      <= '0;
            count_reg         <= '0;
            dropped_reg       <= '0;
            nudged_reg        <= 1'b0;
            acc_reg           <= '0;
            head_pts_reg      <= '0;
            now_reg           <= '0;
            out_valid_reg     <= 1'b0;
            frame_valid_reg   <= 1'b0;
            present_pts_reg   <= '0;
            dropped_count_reg <= '0;
            push_refused_reg  <= 1'b0;
            queue_level_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    afpp_pkg::CFG_STREAM_START: start_reg <= cfg_data;
                    afpp_pkg::CFG_WALL_START:   wall_reg  <= cfg_data;
                    default:                    start_reg <= start_reg;
                endcase
            end

            if (out_load || out_take)
            begin
                out_valid_reg <= out_load;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        priority if (operation == afpp_pkg::OP_PUSH)
                        begin
                            frame_valid_reg   <= 1'b0;
                            present_pts_reg   <= '0;
                            dropped_count_reg <= '0;
                            push_refused_reg  <= queue_full;
                            if (queue_full)
                            begin
                                queue_level_reg <= count_reg[afpp_pkg::LEVEL_W-1:0];
                            end
                            else
                            begin
                                count_reg       <= count_inc;
                                queue_level_reg <= count_inc[afpp_pkg::LEVEL_W-1:0];
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            frame_valid_reg   <= 1'b0;
                            present_pts_reg   <= '0;
                            dropped_count_reg <= '0;
                            push_refused_reg  <= 1'b0;
                            queue_level_reg   <= '0;
                        end
                        else
                        begin
                            now_reg     <= now_ms;
                            dropped_reg <= '0;
                            nudged_reg  <= 1'b0;
                            state_reg   <= S_RDH;
                        end
                    end
                end
                S_RDH:
                begin
                    state_reg <= S_RDR;
                end
                S_RDR:
                begin
                    head_pts_reg <= rd_q_reg;
                    state_reg    <= S_B0;
                end
                S_B0:
                begin
                    acc_reg   <= sum;
                    state_reg <= S_B1;
                end
                S_B1:
                begin
                    acc_reg   <= sum;
                    state_reg <= S_B2;
                end
                S_B2:
                begin
                    acc_reg   <= sum;
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    priority if (!nudged_reg && band_high && sum_pos)
                    begin
                        state_reg <= S_NUDGE;
                    end
                    else if (!nudged_reg && band_low && sum_neg)
                    begin
                        state_reg <= S_NUDGE;
                    end
                    else
                    begin
                        state_reg <= S_D;
                    end
                end
                S_NUDGE:
                begin
                    // recompute the start time with the new anchor
                    anchor_reg <= anchor_sat;
                    nudged_reg <= 1'b1;
                    state_reg  <= S_B0;
                end
                S_D:
                begin
                    acc_reg   <= sum;
                    state_reg <= S_LATE;
                end
                S_LATE:
                begin
                    if (head_drop)
                    begin
                        // drop the late head and test the next one
                        head_ptr_reg <= head_inc;
                        count_reg    <= count_dec;
                        if (dropped_reg != '1)
                        begin
                            dropped_reg <= dropped_reg + afpp_pkg::DROP_W'(1);
                        end
                        nudged_reg <= 1'b0;
                        state_reg  <= S_RDH;
                    end
                    else
                    begin
                        frame_valid_reg   <= 1'b1;
                        present_pts_reg   <= head_pts_reg;
                        dropped_count_reg <= dropped_reg;
                        push_refused_reg  <= 1'b0;
                        queue_level_reg   <= count_reg[afpp_pkg::LEVEL_W-1:0];
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_valid   = frame_valid_reg;
    assign present_pts   = present_pts_reg;
    assign dropped_count = dropped_count_reg;
    assign push_refused  = push_refused_reg;
    assign queue_level   = queue_level_reg;

endmodule

// File: test/tb_top.sv
// Self-checking bench for the frame playout pacer: directed word table, then random pacing traffic.
module tb_top;

    localparam int PTS_W     = afpp_pkg::PTS_W;
    localparam int ANCHOR_W  = afpp_pkg::ANCHOR_W;
    localparam int DROP_W    = afpp_pkg::DROP_W;
    localparam int LEVEL_W   = afpp_pkg::LEVEL_W;
    localparam int CFG_IDX_W = afpp_pkg::CFG_IDX_W;

    localparam int QDEPTH        = afpp_pkg::QUEUE_DEPTH_DEF;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_WORDS = 150;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 1000;
    localparam int LOW_LEAD      = 40;
    localparam int MID_LEAD      = 2;
    localparam int PLAN_ROWS     = 21;

    localparam logic [PTS_W-1:0] PTS_MAX = {PTS_W{1'b1}};
    localparam logic [PTS_W-1:0] PTS_ALT = 42'h2AAAAAAAAAA;
    localparam logic [PTS_W-1:0] PTS_INV = 42'h15555555555;

    localparam longint ANCHOR_HI = (longint'(1) <<< (ANCHOR_W - 1)) - 1;
    localparam longint ANCHOR_LO = -(longint'(1) <<< (ANCHOR_W - 1));

    typedef struct packed {
        logic                frame_valid;
        logic [PTS_W-1:0]    present_pts;
        logic [DROP_W-1:0]   dropped_count;
        logic                push_refused;
        logic [LEVEL_W-1:0]  queue_level;
    } pace_result_t;

    typedef struct packed {
        logic             op;
        logic [PTS_W-1:0] pts;
        logic [PTS_W-1:0] now;
        logic             typed;
        pace_result_t     want;
    } plan_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PTS_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 operation = afpp_pkg::OP_PUSH;
    logic [PTS_W-1:0]     frame_pts = '0;
    logic [PTS_W-1:0]     now_ms    = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b1;
    logic                 frame_valid;
    logic [PTS_W-1:0]     present_pts;
    logic [DROP_W-1:0]    dropped_count;
    logic                 push_refused;
    logic [LEVEL_W-1:0]   queue_level;

    logic [PTS_W-1:0] ts_fifo [QDEPTH];
    int unsigned      fifo_head    = 0;
    int unsigned      fifo_fill    = 0;
    longint           anchor_ms    = 0;
    logic [PTS_W-1:0] stream_start = '0;
    logic [PTS_W-1:0] wall_start   = '0;

    pace_result_t expected_results [$];
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    int           error_count   = 0;
    int           cycle_count   = 0;
    int           hold_left     = 0;
    logic         pressure_req  = 1'b0;
    logic         pressure_done = 1'b0;

    adaptive_frame_playout_pacer_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .frame_pts     (frame_pts),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_valid   (frame_valid),
        .present_pts   (present_pts),
        .dropped_count (dropped_count),
        .push_refused  (push_refused),
        .queue_level   (queue_level)
    );

    always #6 clk = ~clk;

    function automatic longint widen(input logic [PTS_W-1:0] v);
        return longint'({{(64 - PTS_W){1'b0}}, v});
    endfunction

    function automatic logic [PTS_W-1:0] rand_pts();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[PTS_W-1:0];
    endfunction

    function automatic void nudge_anchor(input longint delta);
        longint v;
        v = anchor_ms + delta;
        if (v > ANCHOR_HI)
        begin
            v = ANCHOR_HI;
        end
        if (v < ANCHOR_LO)
        begin
            v = ANCHOR_LO;
        end
        anchor_ms = v;
    endfunction

    function automatic longint head_lateness(input longint now);
        longint n;
        longint rel;
        longint s;
        longint late;
        longint step;
        longint refv;
        int     ref_idx;
        n    = longint'(fifo_fill);
        rel  = widen(ts_fifo[fifo_head]) - widen(stream_start);
        s    = widen(wall_start) + anchor_ms;
        late = rel - (now - s);
        if (n > afpp_pkg::BAND_HIGH)
        begin
            step    = (n <= afpp_pkg::BAND_TOP) ? afpp_pkg::STEP_MID : afpp_pkg::STEP_TOP;
            ref_idx = (int'(fifo_head) + int'(n) - afpp_pkg::REF_OFFSET) % QDEPTH;
            refv    = widen(ts_fifo[ref_idx]) - widen(stream_start);
            if (s > now - refv)
            begin
                nudge_anchor(-step);
                s = widen(wall_start) + anchor_ms;
            end
            late = rel - (now - s + (n - afpp_pkg::BAND_MID) * step);
        end
        else if (n > afpp_pkg::BAND_MID)
        begin
            late = rel - (now - s + (n - afpp_pkg::BAND_MID) * MID_LEAD);
        end
        else if (n <= afpp_pkg::BAND_LOW)
        begin
            if (s < now - rel)
            begin
                nudge_anchor(afpp_pkg::NUDGE_UP);
                s = widen(wall_start) + anchor_ms;
            end
            late = rel - (now - s + (n - afpp_pkg::BAND_LOW) * LOW_LEAD);
        end
        return late;
    endfunction

    function automatic pace_result_t pace_word(input logic op, input logic [PTS_W-1:0] pts,
                                               input logic [PTS_W-1:0] now);
        pace_result_t r;
        longint       late;
        r = '0;
        if (op == afpp_pkg::OP_PUSH)
        begin
            if (fifo_fill >= QDEPTH)
            begin
                r.push_refused = 1'b1;
            end
            else
            begin
                ts_fifo[(fifo_head + fifo_fill) % QDEPTH] = pts;
                fifo_fill = fifo_fill + 1;
            end
        end
        else
        begin
            while (fifo_fill > 0)
            begin
                late = head_lateness(widen(now));
                if (late < 0 && fifo_fill > 1)
                begin
                    fifo_head = (fifo_head + 1) % QDEPTH;
                    fifo_fill = fifo_fill - 1;
                    if (r.dropped_count != {DROP_W{1'b1}})
                    begin
                        r.dropped_count = r.dropped_count + 1'b1;
                    end
                end
                else
                begin
                    r.frame_valid = 1'b1;
                    r.present_pts = ts_fifo[fifo_head];
                    break;
                end
            end
        end
        r.queue_level = LEVEL_W'(fifo_fill);
        return r;
    endfunction

    task automatic send_word(input logic op, input logic [PTS_W-1:0] pts,
                             input logic [PTS_W-1:0] now, input logic typed,
                             input pace_result_t want);
        pace_result_t predicted;
        pace_result_t entry;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        operation <= op;
        frame_pts <= pts;
        now_ms    <= now;
        do @(posedge clk); while (in_stall);
        predicted        = pace_word(op, pts, now);
        entry            = typed ? want : predicted;
        expected_results = {expected_results, entry};
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    task automatic set_timebase(input logic [PTS_W-1:0] start_pts,
                                input logic [PTS_W-1:0] start_wall);
        cfg_we    <= 1'b1;
        cfg_index <= afpp_pkg::CFG_STREAM_START;
        cfg_data  <= start_pts;
        @(posedge clk);
        stream_start = start_pts;
        cfg_index <= afpp_pkg::CFG_WALL_START;
        cfg_data  <= start_wall;
        @(posedge clk);
        wall_start = start_wall;
        cfg_we <= 1'b0;
    endtask

    task automatic run_segment(input int words);
        longint play;
        longint next_off;
        int     target;
        int     left;
        int     sent;
        int     roll;
        play     = longint'($urandom_range(1000000));
        next_off = play + longint'($urandom_range(200));
        sent     = 0;
        while (sent < words)
        begin
            target = ($urandom_range(3) == 0) ? QDEPTH + 2 : int'($urandom_range(QDEPTH));
            left   = $urandom_range(40, 5);
            while (left > 0 && sent < words)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                begin
                    send_word(($urandom_range(1) == 0) ? afpp_pkg::OP_PUSH : afpp_pkg::OP_TICK,
                              rand_pts(), rand_pts(), 1'b0, '0);
                end
                else if (fifo_fill < target && roll < 90)
                begin
                    next_off = next_off + longint'($urandom_range(60)) - 10;
                    send_word(afpp_pkg::OP_PUSH, stream_start + PTS_W'(next_off), rand_pts(),
                              1'b0, '0);
                end
                else
                begin
                    play = play + longint'(($urandom_range(29) == 0) ? $urandom_range(5000)
                                                                      : $urandom_range(50));
                    send_word(afpp_pkg::OP_TICK, rand_pts(), wall_start + PTS_W'(play),
                              1'b0, '0);
                end
                left = left - 1;
                sent = sent + 1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count = error_count + 1;
        end
    endtask

    always @(posedge clk)
    begin
        if (pressure_req && !pressure_done)
        begin
            hold_left     = HOLD_CYCLES;
            pressure_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        pace_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count = error_count + 1;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("frame_valid", 64'(want.frame_valid), 64'(frame_valid));
                check_field("present_pts", 64'(want.present_pts), 64'(present_pts));
                check_field("dropped_count", 64'(want.dropped_count), 64'(dropped_count));
                check_field("push_refused", 64'(want.push_refused), 64'(push_refused));
                check_field("queue_level", 64'(want.queue_level), 64'(queue_level));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        plan_row_t plan [PLAN_ROWS];
        logic [PTS_W-1:0] ss;
        logic [PTS_W-1:0] ws;

        plan[0]  = '{afpp_pkg::OP_TICK, PTS_ALT, '0, 1'b1, '{1'b0, '0, '0, 1'b0, 7'd0}};
        plan[1]  = '{afpp_pkg::OP_TICK, PTS_INV, PTS_MAX, 1'b1, '{1'b0, '0, '0, 1'b0, 7'd0}};
        plan[2]  = '{afpp_pkg::OP_PUSH, '0, PTS_MAX, 1'b1, '{1'b0, '0, '0, 1'b0, 7'd1}};
        plan[3]  = '{afpp_pkg::OP_PUSH, PTS_MAX, '0, 1'b1, '{1'b0, '0, '0, 1'b0, 7'd2}};
        plan[4]  = '{afpp_pkg::OP_TICK, PTS_MAX, '0, 1'b1, '{1'b1, '0, '0, 1'b0, 7'd2}};
        plan[5]  = '{afpp_pkg::OP_TICK, '0, PTS_MAX, 1'b0, '0};
        plan[6]  = '{afpp_pkg::OP_TICK, PTS_ALT, PTS_MAX, 1'b1,
                     '{1'b1, PTS_MAX, '0, 1'b0, 7'd1}};
        plan[7]  = '{afpp_pkg::OP_PUSH, PTS_ALT, PTS_INV, 1'b1, '{1'b0, '0, '0, 1'b0, 7'd2}};
        plan[8]  = '{afpp_pkg::OP_PUSH, PTS_INV, PTS_ALT, 1'b1, '{1'b0, '0, '0, 1'b0, 7'd3}};
        plan[9]  = '{afpp_pkg::OP_TICK, PTS_ALT, PTS_INV, 1'b0, '0};
        plan[10] = '{afpp_pkg::OP_TICK, PTS_INV, PTS_ALT, 1'b0, '0};
        plan[11] = '{afpp_pkg::OP_PUSH, 42'd1000, '0, 1'b0, '0};
        plan[12] = '{afpp_pkg::OP_PUSH, 42'd1040, '0, 1'b0, '0};
        plan[13] = '{afpp_pkg::OP_PUSH, 42'd1040, '0, 1'b0, '0};
        plan[14] = '{afpp_pkg::OP_PUSH, 42'd1010, '0, 1'b0, '0};
        plan[15] = '{afpp_pkg::OP_TICK, '0, 42'd1000, 1'b0, '0};
        plan[16] = '{afpp_pkg::OP_PUSH, 42'd1120, '0, 1'b0, '0};
        plan[17] = '{afpp_pkg::OP_PUSH, 42'd1160, '0, 1'b0, '0};
        plan[18] = '{afpp_pkg::OP_TICK, '0, 42'd1100, 1'b0, '0};
        plan[19] = '{afpp_pkg::OP_TICK, '0, 42'd5000, 1'b0, '0};
        plan[20] = '{afpp_pkg::OP_TICK, '0, '0, 1'b0, '0};

        send_idle_pct = 31;
        recv_idle_pct = 83;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            send_word(plan[i].op, plan[i].pts, plan[i].now, plan[i].typed, plan[i].want);
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_idle();
            case (seg)
                1:       begin ss = PTS_MAX; ws = '0;      end
                2:       begin ss = '0;      ws = PTS_MAX; end
                3:       begin ss = PTS_MAX; ws = PTS_MAX; end
                default: begin ss = rand_pts(); ws = rand_pts(); end
            endcase
            set_timebase(ss, ws);
            if (seg < 2)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 83;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seg == 4)
            begin
                pressure_req <= 1'b1;
            end
            run_segment(SEGMENT_WORDS);
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/afpp_pkg.sv
rtl/afpp_alu.sv
rtl/adaptive_frame_playout_pacer_core.sv
test/tb_top.sv
